### hw/rtl/isp_pkg.sv
// Shared definitions for the idle state predictor.
// Holds the default ring depth, the depth thresholds, register indexes
// and the divider status type; depends on nothing.
package isp_pkg;

  localparam int unsigned RingDepthDef = 16;

  localparam logic [31:0] LevelShallowUs = 32'd10;
  localparam logic [31:0] LevelMediumUs  = 32'd100;
  localparam logic [31:0] LevelLongUs    = 32'd500;

  localparam logic [1:0] RegPredictEnable = 2'd0;
  localparam logic [1:0] RegNormalMax     = 2'd1;
  localparam logic [1:0] RegDeepMax       = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } isp_div_stat_t;

endpackage

### hw/rtl/idle_state_predictor.sv
// Top level of the idle state predictor: sequencer, history ring, totals,
// configuration registers and output register. Depends on isp_pkg and isp_div.
//
// Channel    Direction  Handshake                     Payload
// s_axis     in         s_axis_tvalid / s_axis_tready tdata, tuser
// m_axis     out        m_axis_tvalid / m_axis_tready tdata
// apb        in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// The serial divider forms the average one quotient bit per cycle.
// The block takes no new item until the previous one is in the output
// register; a waiting result stalls the sequencer in its last step only.
// Reset is asynchronous; the history ring itself is not cleared.
module idle_state_predictor #(
  parameter int unsigned RING_DEPTH = isp_pkg::RingDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // episode length in us
  input  logic [1:0]   s_axis_tuser,   // deep_request, restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // target_depth, average_us, idle_total_us,
                                       // wakeup_total, zero padding
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import isp_pkg::*;

  localparam int unsigned FillW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SlotW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SumW  = 32 + FillW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_SUB   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic             pred_en_q;
  logic [2:0]       normal_max_q, deep_max_q;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [63:0]      idle_q, idle_d;
  logic [63:0]      wakeup_q, wakeup_d;
  logic [31:0]      dur_q;
  logic             deep_q, restart_q;
  logic [31:0]      avg_q, avg_d;
  logic [31:0]      rd_q;
  logic [31:0]      hist_mem [RING_DEPTH];
  logic             out_valid_q;
  logic [167:0]     out_data_q;
  logic             in_accept, full, div_start, out_load;
  logic [2:0]       proposal, limit, depth;
  logic [31:0]      quotient;
  isp_div_stat_t    div_stat;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_en_q    <= 1'b1;
      normal_max_q <= 3'd3;
      deep_max_q   <= 3'd6;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegPredictEnable: pred_en_q    <= pwdata[0];
        RegNormalMax:     normal_max_q <= pwdata[2:0];
        RegDeepMax:       deep_max_q   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegPredictEnable: prdata = {31'd0, pred_en_q};
      RegNormalMax:     prdata = {29'd0, normal_max_q};
      RegDeepMax:       prdata = {29'd0, deep_max_q};
      default:          prdata = '0;
    endcase
  end

  // Sequencer
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign full          = (fill_q == FillW'(RING_DEPTH));
  assign div_start     = (state_q == S_START) && pred_en_q && (fill_q != '0);
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    idle_d   = idle_q;
    wakeup_d = wakeup_q;
    avg_d    = avg_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_START;
          if (s_axis_tuser[1]) begin
            slot_d = '0;
            fill_d = '0;
            sum_d  = '0;
          end
        end
      end
      S_START: begin
        if (div_start) begin
          state_d = S_WAIT;
        end else begin
          avg_d   = '0;
          state_d = S_SUB;
        end
      end
      S_WAIT: begin
        if (div_stat.done) begin
          avg_d   = quotient;
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        state_d = S_ADD;
        if (!restart_q) begin
          if (full) begin
            sum_d = sum_q - SumW'(rd_q);
          end else begin
            fill_d = fill_q + FillW'(1);
          end
        end
      end
      S_ADD: begin
        state_d = S_OUT;
        if (!restart_q) begin
          sum_d    = sum_q + SumW'(dur_q);
          slot_d   = (slot_q == SlotW'(RING_DEPTH - 1)) ? '0 : slot_q + SlotW'(1);
          idle_d   = idle_q + 64'(dur_q);
          wakeup_d = wakeup_q + 64'd1;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      slot_q   <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      idle_q   <= '0;
      wakeup_q <= '0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      idle_q   <= idle_d;
      wakeup_q <= wakeup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
    if (in_accept) begin
      dur_q     <= s_axis_tdata;
      deep_q    <= s_axis_tuser[0];
      restart_q <= s_axis_tuser[1];
    end
  end

  // History ring
  always_ff @(posedge clk_i) begin
    if (state_q == S_START) begin
      rd_q <= hist_mem[slot_q];
    end
    if (state_q == S_ADD && !restart_q) begin
      hist_mem[slot_q] <= dur_q;
    end
  end

  isp_div #(
    .SumW (SumW),
    .CntW (FillW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // Depth choice; an average of zero also gives the empty-window proposal of one.
  always_comb begin
    if (avg_q < LevelShallowUs) begin
      proposal = 3'd1;
    end else if (avg_q < LevelMediumUs) begin
      proposal = 3'd2;
    end else if (avg_q < LevelLongUs) begin
      proposal = 3'd3;
    end else begin
      proposal = 3'd4;
    end
    limit = deep_q ? deep_max_q : normal_max_q;
    depth = (proposal > limit) ? limit : proposal;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {5'd0, wakeup_q, idle_q, avg_q, depth};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(RING_DEPTH))
    else $error("Fill count beyond the ring depth.");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (sum_q == '0))
    else $error("Window sum not zero with an empty window.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("Item taken while the previous one is still at work.");

  a_wakeup_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(wakeup_q) |-> ($past(state_q) == S_ADD) && !$past(restart_q))
    else $error("Wakeup count moved outside the recording step.");

endmodule

### hw/rtl/isp_div.sv
// Restoring divider for the history average, one quotient bit per cycle.
// Depends on isp_pkg for its status type.
module isp_div #(
  parameter int unsigned SumW = 37,
  parameter int unsigned CntW = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SumW-1:0]       dividend_i,
  input  logic [CntW-1:0]       divisor_i,
  output logic [31:0]           quotient_o,
  output isp_pkg::isp_div_stat_t stat_o
);
  import isp_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  div_q;
  logic [StepW-1:0] step_q, step_d;
  logic             done_q, done_d;
  logic [CntW:0]    trial;
  logic             fits;

  assign trial = {rem_q, quo_q[SumW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      step_d = StepW'(SumW);
    end else if (step_q != '0) begin
      quo_d  = {quo_q[SumW-2:0], fits};
      rem_d  = fits ? CntW'(trial - {1'b0, div_q}) : trial[CntW-1:0];
      step_d = step_q - StepW'(1);
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign quotient_o  = quo_q[31:0];
  assign stat_o.busy = (step_q != '0);
  assign stat_o.done = done_q;

endmodule
